// ===== hw/rtl/ded_pkg.sv =====
// Package with shared types and constants for the delay embedding distance core.
package ded_pkg;

    localparam int DefMaxDim       = 8;
    localparam int DefMaxDelay     = 32;
    localparam int DefHistoryDepth = 256;
    localparam int DefMaxSamples   = 65536;
    localparam int DefSampleBits   = 16;

    localparam int SampleW  = 16;
    localparam int DimW     = 4;
    localparam int DelayW   = 6;
    localparam int MeanW    = 18;
    localparam int CountW   = 17;
    localparam int SumW     = 35;
    localparam int SqW      = 36;
    localparam int RootW    = 18;

    localparam logic [0:0] RegEmbedDim = 1'b0;
    localparam logic [0:0] RegTapDelay = 1'b1;

    typedef struct packed {
        logic signed [SampleW-1:0] sample_a;
        logic signed [SampleW-1:0] sample_b;
        logic                      last_sample;
    } in_item_t;

    typedef struct packed {
        logic [MeanW-1:0]  mean_distance;
        logic [CountW-1:0] row_count;
        logic              no_rows;
        logic              count_overflow;
    } out_item_t;

endpackage

// ===== hw/rtl/delay_embedding_distance_core.sv =====
// Top level of the delay embedding distance core: history memory, sequencer and result.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall  | ded_pkg::in_item_t
//   out     | output    | out_valid/out_stall| ded_pkg::out_item_t
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A transaction that completes a row occupies the core through the accept, a tap read and an
// accumulate step for each of the dim taps (dim is the clamped embed_dim) and the square root;
// a transaction that completes no row returns the core to idle, unless it is last. A last
// transaction adds the divider. Tap reads go through the single read port of each history
// memory, each read followed by its accumulate step. After reset the core sweeps the history
// memories to zero, one entry per cycle, and stalls the input meanwhile. A waiting result
// sits in the output register; the next transaction is taken while it waits, unless it is last.
module delay_embedding_distance_core
#(
    parameter int MAX_DELAY     = ded_pkg::DefMaxDelay,
    parameter int HISTORY_DEPTH = ded_pkg::DefHistoryDepth
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  ded_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output ded_pkg::out_item_t         out_data,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [ded_pkg::DelayW-1:0] cfg_data
);
    import ded_pkg::*;

    // Limits tied to the fixed field widths of the package.
    localparam int MAX_DIM     = DefMaxDim;
    localparam int MAX_SAMPLES = DefMaxSamples;
    localparam int SAMPLE_BITS = DefSampleBits;

    localparam int AddrW = $clog2(HISTORY_DEPTH);
    localparam int TapW  = $clog2(MAX_DIM + 1);
    localparam int BackW = $clog2(MAX_DIM * MAX_DELAY + 1);
    localparam int SampW = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_ACC   = 7'b0001000,
        S_ROOT  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [DimW-1:0]   dim_reg;
    logic [DelayW-1:0] dly_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DimW'(2);
            dly_reg <= DelayW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegEmbedDim: dim_reg <= cfg_data[DimW-1:0];
                RegTapDelay: dly_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Clamped dimension and delay.
    logic [TapW-1:0]  dim_c;
    logic [BackW-1:0] dly_c;
    logic [BackW-1:0] span_m1;

    always_comb
    begin
        if (dim_reg == '0)
            dim_c = TapW'(1);
        else if (32'(dim_reg) > MAX_DIM)
            dim_c = TapW'(MAX_DIM);
        else
            dim_c = TapW'(dim_reg);
        if (dly_reg == '0)
            dly_c = BackW'(1);
        else if (32'(dly_reg) > MAX_DELAY)
            dly_c = BackW'(MAX_DELAY);
        else
            dly_c = BackW'(dly_reg);
    end

    // Series state.
    logic [AddrW-1:0]  wp_reg, wp_next;
    logic [SampW-1:0]  seen_reg, seen_next;
    logic [SumW-1:0]   sum_reg, sum_next;
    logic [CountW-1:0] rows_reg, rows_next;
    logic              ovf_reg, ovf_next;
    logic              last_reg, last_next;
    logic [TapW-1:0]   tap_reg, tap_next;
    logic [BackW-1:0]  back_reg, back_next;
    logic [SqW-1:0]    sq_reg, sq_next;
    logic [AddrW-1:0]  clr_reg, clr_next;
    logic              rvalid_reg, rvalid_next;
    out_item_t         out_reg, out_next;
    logic              ovalid_reg, ovalid_next;

    // History memories, one write and one read port each.
    logic [SAMPLE_BITS-1:0] mem_a [HISTORY_DEPTH];
    logic [SAMPLE_BITS-1:0] mem_b [HISTORY_DEPTH];
    logic                   mem_we;
    logic [AddrW-1:0]       mem_waddr, mem_raddr;
    logic [SAMPLE_BITS-1:0] mem_wa, mem_wb, rd_a, rd_b;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_a[mem_waddr] <= mem_wa;
            mem_b[mem_waddr] <= mem_wb;
        end
        rd_a <= mem_a[mem_raddr];
        rd_b <= mem_b[mem_raddr];
    end

    // Difference and square of the tap read in the previous cycle.
    logic signed [SAMPLE_BITS:0] diff;
    logic [SAMPLE_BITS:0]        mag;
    logic [SqW-1:0]              sq_term;

    assign diff    = $signed({rd_a[SAMPLE_BITS-1], rd_a}) - $signed({rd_b[SAMPLE_BITS-1], rd_b});
    assign mag     = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : diff;
    assign sq_term = SqW'(mag * mag);

    // Square root and divider units.
    logic             root_start, root_done;
    logic [RootW-1:0] root;
    logic             div_start, div_done;
    logic [SumW-1:0]  quotient;

    ded_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sq_reg),
        .done     (root_done),
        .root     (root)
    );

    ded_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (rows_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    logic in_acc, out_acc, tap_last;

    assign in_stall  = (state_reg != S_IDLE) || (ovalid_reg && in_data.last_sample);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = ovalid_reg && !out_stall;
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;
    assign span_m1   = BackW'((TapW + BackW)'(dim_c - 1'b1) * dly_c);
    assign tap_last  = (tap_reg == dim_c - 1'b1);

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        seen_next   = seen_reg;
        sum_next    = sum_reg;
        rows_next   = rows_reg;
        ovf_next    = ovf_reg;
        last_next   = last_reg;
        tap_next    = tap_reg;
        back_next   = back_reg;
        sq_next     = sq_reg;
        clr_next    = clr_reg;
        rvalid_next = 1'b0;
        out_next    = out_reg;
        ovalid_next = ovalid_reg && !out_acc;
        mem_we      = 1'b0;
        mem_waddr   = wp_reg;
        mem_wa      = in_data.sample_a[SAMPLE_BITS-1:0];
        mem_wb      = in_data.sample_b[SAMPLE_BITS-1:0];
        mem_raddr   = wp_reg - AddrW'(back_reg);
        root_start  = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wa    = '0;
                mem_wb    = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AddrW'(HISTORY_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    last_next = in_data.last_sample;
                    if (32'(seen_reg) >= MAX_SAMPLES)
                    begin
                        ovf_next   = 1'b1;
                        state_next = in_data.last_sample ? S_DIV : S_IDLE;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        seen_next = seen_reg + 1'b1;
                        if (32'(seen_reg) >= 32'(span_m1))
                        begin
                            tap_next   = '0;
                            back_next  = span_m1;
                            sq_next    = '0;
                            state_next = S_READ;
                        end
                        else
                        begin
                            wp_next    = wp_reg + 1'b1;
                            state_next = in_data.last_sample ? S_DIV : S_IDLE;
                        end
                    end
                end
            end
            S_READ:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sq_next = sq_reg + sq_term;
                if (tap_last)
                begin
                    rvalid_next = 1'b1;
                    state_next  = S_ROOT;
                end
                else
                begin
                    tap_next   = tap_reg + 1'b1;
                    back_next  = back_reg - dly_c;
                    state_next = S_READ;
                end
            end
            S_ROOT:
            begin
                if (!rvalid_reg && root_done)
                begin
                    sum_next   = sum_reg + SumW'(root);
                    rows_next  = rows_reg + 1'b1;
                    wp_next    = wp_reg + 1'b1;
                    state_next = last_reg ? S_DIV : S_IDLE;
                end
                root_start = rvalid_reg;
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (div_done && !ovalid_reg)
                begin
                    out_next.mean_distance  = (rows_reg == '0) ? '0 : quotient[MeanW-1:0];
                    out_next.row_count      = rows_reg;
                    out_next.no_rows        = (rows_reg == '0);
                    out_next.count_overflow = ovf_reg;
                    ovalid_next = 1'b1;
                    wp_next     = '0;
                    seen_next   = '0;
                    sum_next    = '0;
                    rows_next   = '0;
                    ovf_next    = '0;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // rvalid marks the entry into the root step; reused to start the root unit once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            wp_reg     <= '0;
            seen_reg   <= '0;
            sum_reg    <= '0;
            rows_reg   <= '0;
            ovf_reg    <= 1'b0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            seen_reg   <= seen_next;
            sum_reg    <= sum_next;
            rows_reg   <= rows_next;
            ovf_reg    <= ovf_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        tap_reg  <= tap_next;
        back_reg <= back_next;
        sq_reg   <= sq_next;
        out_reg  <= out_next;
    end

endmodule

// ===== hw/rtl/ded_isqrt.sv =====
// Iterative integer square root, one result bit per pass, one pass per cycle.
module ded_isqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [ded_pkg::SqW-1:0] radicand,
    output logic                   done,
    output logic [ded_pkg::RootW-1:0] root
);
    import ded_pkg::*;

    localparam int StepW = $clog2(SqW / 2 + 1);

    logic [SqW-1:0]   rem_reg, rem_next;
    logic [SqW-1:0]   res_reg, res_next;
    logic [SqW-1:0]   bit_reg, bit_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SqW-1:0]   trial;

    assign trial = res_reg + bit_reg;

    // Load on start, else one restoring step of the digit-by-digit root.
    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = {2'b01, {(SqW-2){1'b0}}};
            step_next = StepW'(SqW / 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[RootW-1:0];
endmodule

// ===== hw/rtl/ded_divider.sv =====
// Iterative restoring divider for the mean, one quotient bit per cycle.
module ded_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ded_pkg::SumW-1:0]   dividend,
    input  logic [ded_pkg::CountW-1:0] divisor,
    output logic                     done,
    output logic [ded_pkg::SumW-1:0]   quotient
);
    import ded_pkg::*;

    localparam int CntW = $clog2(SumW + 1);

    logic [SumW-1:0]   quo_reg, quo_next;
    logic [CountW:0]   rem_reg, rem_next;
    logic [CountW-1:0] den_reg, den_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CountW:0]   shifted;

    assign shifted = {rem_reg[CountW-1:0], quo_reg[SumW-1]};

    // Load on start, else shift in one dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CntW'(SumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[SumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[SumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== sim/tb_delay_embedding_distance_core.sv =====
// Self-checking testbench for the delay embedding distance core.
`timescale 1ns / 1ps

module tb_delay_embedding_distance_core;
    import ded_pkg::*;

    localparam int HistDepth  = 256;
    localparam int SampleCap  = 65536;
    localparam int IdleLimit  = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_stall;
    out_item_t          out_data;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [DelayW-1:0]  cfg_data;

    delay_embedding_distance_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: a copy of the series history and running sums.
    logic signed [SampleW-1:0] hist_a [HistDepth];
    logic signed [SampleW-1:0] hist_b [HistDepth];
    logic [7:0]        wr_ptr;
    logic [16:0]       seen_count;
    logic [SumW-1:0]   dist_sum;
    logic              sat_flag;
    logic [16:0]       rows_accum;
    logic [DimW-1:0]   dim_reg;
    logic [DelayW-1:0] delay_reg;

    in_item_t  pending_items[$];
    out_item_t expected_means[$];
    int        fail_count;
    bit        quiet_phase;
    int        idle_cycles;

    // Clock.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [RootW-1:0] floor_sqrt(input logic [SqW-1:0] val);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = 64'(val);
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root[RootW-1:0];
    endfunction

    // Appends one transaction to the pending input queue.
    task automatic queue_item(input in_item_t item);
        pending_items = {pending_items, item};
    endtask

    // Applies one accepted transaction to the predictor.
    task automatic predict_distance(input in_item_t item);
        int unsigned dim;
        int unsigned dly;
        int unsigned span;
        int unsigned back;
        int unsigned idx;
        logic [SqW-1:0] sq;
        logic signed [SampleW:0] diff;
        out_item_t res;
        dim = (dim_reg < 1) ? 1 : (dim_reg > 8) ? 8 : dim_reg;
        dly = (delay_reg < 1) ? 1 : (delay_reg > 32) ? 32 : delay_reg;
        span = (dim - 1) * dly + 1;
        if (seen_count >= SampleCap)
            sat_flag = 1'b1;
        else
        begin
            hist_a[wr_ptr] = item.sample_a;
            hist_b[wr_ptr] = item.sample_b;
            seen_count++;
            if (seen_count >= span)
            begin
                sq = 0;
                for (int t = 0; t < dim; t++)
                begin
                    back = ((dim - 1 - t) * dly) % HistDepth;
                    idx  = (wr_ptr + HistDepth - back) % HistDepth;
                    diff = {hist_a[idx][SampleW-1], hist_a[idx]}
                         - {hist_b[idx][SampleW-1], hist_b[idx]};
                    if (diff < 0)
                        diff = -diff;
                    sq += SqW'(diff) * SqW'(diff);
                end
                dist_sum += SumW'(floor_sqrt(sq));
                rows_accum++;
            end
            wr_ptr++;
        end
        if (item.last_sample)
        begin
            res.mean_distance  = (rows_accum != 0) ? MeanW'(dist_sum / rows_accum) : '0;
            res.row_count      = rows_accum;
            res.no_rows        = (rows_accum == 0);
            res.count_overflow = sat_flag;
            expected_means = {expected_means, res};
            wr_ptr = 0;
            seen_count = 0;
            dist_sum = 0;
            sat_flag = 0;
            rows_accum = 0;
        end
    endtask

    // Input monitor: feeds each accepted input transaction to the predictor.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_distance(in_data);
            void'(pending_items.pop_front());
        end
    end

    // Driver: presents queued transactions with random gaps.
    int gap_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (!(in_valid && in_stall) && !quiet_phase && $urandom_range(0, 9) == 0)
            begin
                gap_left = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_items[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall bursts.
    int stall_left;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_means.size() == 0)
            begin
                $error("unexpected result transaction");
                fail_count++;
            end
            else
            begin
                out_item_t exp_res;
                exp_res = expected_means.pop_front();
                if (out_data.mean_distance !== exp_res.mean_distance)
                begin
                    $error("mean_distance: expected %0d, actual %0d",
                           exp_res.mean_distance, out_data.mean_distance);
                    fail_count++;
                end
                if (out_data.row_count !== exp_res.row_count)
                begin
                    $error("row_count: expected %0d, actual %0d",
                           exp_res.row_count, out_data.row_count);
                    fail_count++;
                end
                if (out_data.no_rows !== exp_res.no_rows)
                begin
                    $error("no_rows: expected %0d, actual %0d",
                           exp_res.no_rows, out_data.no_rows);
                    fail_count++;
                end
                if (out_data.count_overflow !== exp_res.count_overflow)
                begin
                    $error("count_overflow: expected %0d, actual %0d",
                           exp_res.count_overflow, out_data.count_overflow);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic in_item_t make_pair(input logic [15:0] a, input logic [15:0] b,
                                           input logic last);
        in_item_t it;
        it.sample_a    = a;
        it.sample_b    = b;
        it.last_sample = last;
        return it;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain();
        wait (pending_items.size() == 0 && !in_valid);
        wait (expected_means.size() == 0);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [DelayW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == RegEmbedDim)
            dim_reg = val[DimW-1:0];
        else
            delay_reg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_series(input int len);
        for (int i = 0; i < len; i++)
            queue_item(make_pair(rand_sample(), rand_sample(), i == len - 1));
    endtask

    // Stimulus.
    initial
    begin
        int sent;
        int len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = RegEmbedDim;
        cfg_data = '0;
        fail_count = 0;
        quiet_phase = 0;
        idle_cycles = 0;
        gap_left = 0;
        stall_left = 0;
        wr_ptr = 0;
        seen_count = 0;
        dist_sum = 0;
        sat_flag = 0;
        rows_accum = 0;
        dim_reg = 2;
        delay_reg = 1;
        for (int i = 0; i < HistDepth; i++)
        begin
            hist_a[i] = 0;
            hist_b[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: a lone last item with no rows, and short series of extremes.
        queue_item(make_pair(16'h0000, 16'h0000, 1'b1));
        queue_item(make_pair(16'h7FFF, 16'h8000, 1'b0));
        queue_item(make_pair(16'h8000, 16'h7FFF, 1'b0));
        queue_item(make_pair(16'h7FFF, 16'h8000, 1'b1));
        queue_item(make_pair(16'hFFFF, 16'h0001, 1'b0));
        queue_item(make_pair(16'h1234, 16'h1234, 1'b1));
        drain();

        // Zero values act as one; extremes and oversize values saturate.
        write_reg(RegEmbedDim, 6'd0);
        write_reg(RegTapDelay, 6'd0);
        queue_item(make_pair(16'h7FFF, 16'h8000, 1'b0));
        queue_item(make_pair(16'h8000, 16'h7FFF, 1'b1));
        drain();
        write_reg(RegEmbedDim, 6'd8);
        write_reg(RegTapDelay, 6'd32);
        queue_series(10);
        drain();
        write_reg(RegEmbedDim, 6'd15);
        write_reg(RegTapDelay, 6'd63);
        queue_series(230);
        drain();

        // Random series across several register settings; the count includes the
        // directed transactions above.
        sent = 248;
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(RegEmbedDim, 6'($urandom_range(0, 15)));
            write_reg(RegTapDelay, 6'($urandom_range(0, 63)));
            for (int s = 0; s < 8; s++)
            begin
                len = $urandom_range(1, 25);
                queue_series(len);
                sent += len;
            end
            if (phase == 6)
                quiet_phase = 1;
            drain();
        end
        write_reg(RegEmbedDim, 6'd2);
        write_reg(RegTapDelay, 6'd1);
        while (sent < 1000)
        begin
            len = $urandom_range(1, 12);
            queue_series(len);
            sent += len;
        end
        drain();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ded_pkg.sv
hw/rtl/ded_isqrt.sv
hw/rtl/ded_divider.sv
hw/rtl/delay_embedding_distance_core.sv
sim/tb_delay_embedding_distance_core.sv
